// ===== rtl/core/sma_pkg.sv =====
// Shared types and constants for the simple moving average block.
// Holds the word structs of both channels and the controller/datapath interface.
// Depends on nothing.
package sma_pkg;

    localparam int DEF_MAX_WINDOW = 256;
    localparam int PRICE_W        = 32;
    localparam int LEN_W          = 9;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 9;

    localparam logic [LEN_W-1:0]     LEN_RESET          = 9'd14;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARTIAL_OUTPUT = 1'd1;

    typedef struct packed {
        logic               mode;
        logic [PRICE_W-1:0] price;
    } sma_sample_t;

    typedef struct packed {
        logic [PRICE_W-1:0] average;
        logic               window_full;
    } sma_result_t;

    typedef struct packed {
        logic capture;
        logic update;
        logic div_step;
        logic load_out;
    } sma_cmd_t;

    typedef struct packed {
        logic div_last;
    } sma_stat_t;

endpackage

// ===== rtl/core/sma_ctrl.sv =====
// Controller state machine for the simple moving average block.
// Sequences capture, window update, divider steps and output load.
// Depends on sma_pkg.
module sma_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    output logic              result_valid,
    input  logic              result_stall,
    input  sma_pkg::sma_stat_t stat,
    output sma_pkg::sma_cmd_t  cmd
);
    import sma_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_LOAD   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/sma_datapath.sv =====
// Datapath for the simple moving average block: configuration registers,
// price window memory, running sum, bar count, bit-serial divider, output word.
// Depends on sma_pkg.
module sma_datapath #(
    parameter int MAX_WINDOW = sma_pkg::DEF_MAX_WINDOW
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [sma_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sma_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  sma_pkg::sma_sample_t                 sample,
    input  sma_pkg::sma_cmd_t                    cmd,
    output sma_pkg::sma_stat_t                   stat,
    output sma_pkg::sma_result_t                 result
);
    import sma_pkg::*;

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SUM_W  = PRICE_W + CNT_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [LEN_W-1:0]   len_reg;
    logic               partial_reg;
    logic [AW-1:0]      slot_reg;
    logic [CNT_W-1:0]   bars_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [PRICE_W-1:0] mem [MAX_WINDOW];
    logic [PRICE_W-1:0] rd_data_reg;
    logic [PRICE_W-1:0] price_reg;
    logic               revise_reg;
    logic               evict_reg;

    logic [SUM_W-1:0]   quo_reg;
    logic [CNT_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   div_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               full_reg;
    logic               zero_reg;
    sma_result_t        result_reg;

    logic [CNT_W-1:0]   eff_len;
    logic [CNT_W-1:0]   slot_ext;
    logic [AW-1:0]      last_addr;
    logic [AW-1:0]      old_addr;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               revise;
    logic               evict;
    logic [PRICE_W-1:0] drop_price;
    logic [SUM_W-1:0]   sum_next;
    logic [CNT_W-1:0]   bars_next;
    logic [AW-1:0]      slot_next;
    logic               full_next;
    logic [CNT_W:0]     rem_sh;
    logic [CNT_W:0]     rem_diff;
    logic               quo_bit;

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (CMP_W'(len_reg) > CMP_W'(MAX_WINDOW))
        begin
            eff_len = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_len = CNT_W'(len_reg);
        end
    end

    assign slot_ext  = CNT_W'(slot_reg);
    assign last_addr = (slot_reg == '0) ? AW'(MAX_WINDOW - 1) : slot_reg - AW'(1);
    assign old_addr  = (slot_ext >= eff_len) ? AW'(slot_ext - eff_len)
                                             : AW'(slot_ext + CNT_W'(MAX_WINDOW) - eff_len);
    assign revise    = sample.mode && (bars_reg != '0);
    assign evict     = !revise && (bars_reg >= eff_len);
    assign rd_addr   = revise ? last_addr : old_addr;
    assign wr_addr   = revise_reg ? last_addr : slot_reg;

    // Window update, evaluated in the update cycle
    always_comb
    begin
        drop_price = (revise_reg || evict_reg) ? rd_data_reg : '0;
        sum_next   = sum_reg - SUM_W'(drop_price) + SUM_W'(price_reg);
        bars_next  = bars_reg;
        slot_next  = slot_reg;
        if (!revise_reg && !evict_reg)
        begin
            bars_next = bars_reg + CNT_W'(1);
        end
        if (!revise_reg)
        begin
            slot_next = (slot_reg == AW'(MAX_WINDOW - 1)) ? '0 : slot_reg + AW'(1);
        end
        full_next = (bars_next >= eff_len);
    end

    // One quotient bit per step
    assign rem_sh   = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, div_reg};
    assign quo_bit  = (rem_sh >= {1'b0, div_reg});

    assign stat.div_last = (step_reg == STEP_W'(1));
    assign result        = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_RESET;
            partial_reg <= 1'b0;
            slot_reg    <= '0;
            bars_reg    <= '0;
            sum_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW_LENGTH:
                begin
                    len_reg  <= cfg_data[LEN_W-1:0];
                    slot_reg <= '0;
                    bars_reg <= '0;
                    sum_reg  <= '0;
                end
                REG_PARTIAL_OUTPUT:
                begin
                    partial_reg <= cfg_data[0];
                    slot_reg    <= '0;
                    bars_reg    <= '0;
                    sum_reg     <= '0;
                end
                default:
                begin
                    partial_reg <= partial_reg;
                end
            endcase
        end
        else if (cmd.update)
        begin
            slot_reg <= slot_next;
            bars_reg <= bars_next;
            sum_reg  <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (cmd.update)
        begin
            mem[wr_addr] <= price_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            price_reg  <= sample.price;
            revise_reg <= revise;
            evict_reg  <= evict;
        end
        if (cmd.update)
        begin
            quo_reg  <= sum_next;
            rem_reg  <= '0;
            div_reg  <= bars_next;
            step_reg <= STEP_W'(SUM_W);
            full_reg <= full_next;
            zero_reg <= !(full_next || partial_reg) || (bars_next == '0);
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], quo_bit};
            rem_reg  <= quo_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            step_reg <= step_reg - STEP_W'(1);
        end
        if (cmd.load_out)
        begin
            result_reg.average     <= zero_reg ? '0 : quo_reg[PRICE_W-1:0];
            result_reg.window_full <= full_reg;
        end
    end

endmodule

// ===== rtl/core/simple_moving_average.sv =====
// Top level of the simple moving average block over unsigned Q16.16 prices.
// Joins the controller (sma_ctrl) and the datapath (sma_datapath); uses sma_pkg.
//
//   channel  | handshake                    | word
//   sample   | sample_valid / sample_stall  | sma_sample_t {mode, price}
//   result   | result_valid / result_stall  | sma_result_t {average, window_full}
//   config   | cfg_we                       | cfg_index, cfg_data
//
// One word passes through capture, window update, the one-bit-per-cycle divider
// and output load between accept and result.
// A new sample is taken once the previous result sits in the output register.
// Reset clears the history and loads window_length 14, partial_output 0.
// A stalled result holds the output register and delays only the next load.
module simple_moving_average #(
    parameter int MAX_WINDOW = sma_pkg::DEF_MAX_WINDOW
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           sample_valid,
    output logic                           sample_stall,
    input  sma_pkg::sma_sample_t           sample,
    output logic                           result_valid,
    input  logic                           result_stall,
    output sma_pkg::sma_result_t           result,
    input  logic                           cfg_we,
    input  logic [sma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sma_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sma_pkg::*;

    sma_cmd_t  cmd;
    sma_stat_t stat;

    sma_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    sma_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample),
        .cmd       (cmd),
        .stat      (stat),
        .result    (result)
    );

endmodule
